// File: sv/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, codes, reset values and types for the line follower PID
// steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

   // default number of line sensors wired to the block
   localparam int LFPS_NUM_SENSORS = 8;

   // field and datapath widths
   localparam int SENSOR_W  = 8;   // sensor bit field
   localparam int CNT_W     = 4;   // active sensor count, 0..8
   localparam int IDX_W     = 5;   // sum of active indexes, 0..28
   localparam int WSUM_W    = 15;  // 1000 * index sum, 0..28000
   localparam int POS_W     = 13;  // line position, 0..7000
   localparam int ERR_W     = 13;  // error, -4096..4095
   localparam int DLT_W     = 14;  // error difference
   localparam int SUM_W     = 32;  // integral
   localparam int GAIN_W    = 16;  // Q8.8 gains
   localparam int OPND_W    = 33;  // multiplier data operand
   localparam int PROD_W    = GAIN_W + OPND_W;
   localparam int ACC_W     = 51;  // sum of three products
   localparam int SPD_W     = 8;
   localparam int MODE_W    = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // position and speed constants
   localparam int POS_STEP   = 1000;
   localparam int POS_CENTER = 3500;
   localparam int POS_RIGHT  = 7000;
   localparam int ERR_MAX    = 4095;
   localparam int ERR_MIN    = -4096;
   localparam logic [SPD_W-1:0] CROSS_SPEED = 8'd180;
   localparam logic [SPD_W-1:0] NORM_LO     = 8'd60;
   localparam logic [SPD_W-1:0] NORM_HI     = 8'd200;
   localparam logic [SPD_W-1:0] SPD_MAX     = 8'd255;
   localparam logic [CNT_W-1:0] CURVE_MAX_CNT = 4'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DERIV_GAIN = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_SPEED = 2'd3;

   // register reset values
   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd7680;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd3840;
   localparam logic [SPD_W-1:0]         BASE_SPEED_RST = 8'd120;

   // drive modes
   typedef enum logic [MODE_W-1:0] {
      MODE_NORMAL = 2'd0,
      MODE_CURVE  = 2'd1,
      MODE_CROSS  = 2'd2
   } mode_type;

   // control from sequencer to the shared multiply-accumulate unit
   typedef struct packed {
      logic valid;   // a product term is issued this cycle
      logic first;   // this term restarts the accumulator
   } mac_ctrl_type;

endpackage

// File: sv/lfps_div.sv
// ----------------------------------------------------------------------------
// lfps_div
// Serial restoring divider: one quotient bit per cycle, used to turn the
// weighted sensor sum into the mean line position.
// ----------------------------------------------------------------------------
module lfps_div import lfps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WSUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              busy,
   output logic [WSUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(WSUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WSUM_W - 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WSUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, quo_ff[WSUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[WSUM_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         busy_in = (step_ff != LAST_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/lfps_mac.sv
// ----------------------------------------------------------------------------
// lfps_mac
// Shared multiply-accumulate unit: one signed gain by data product per cycle,
// product registered, then summed into the PID output accumulator.
// ----------------------------------------------------------------------------
module lfps_mac import lfps_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [GAIN_W-1:0] gain,
   input  logic signed [OPND_W-1:0] opnd,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pvld_ff, pvld_in;
   logic                     pfirst_ff, pfirst_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  acc_base;

   // multiplier stage
   always_comb begin
      prod_in   = gain * opnd;
      pvld_in   = ctrl.valid;
      pfirst_in = ctrl.first;
   end

   // accumulate stage
   always_comb begin
      acc_base = pfirst_ff ? '0 : acc_ff;
      acc_in   = acc_ff;
      if (pvld_ff) begin
         acc_in = acc_base + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= pvld_in;
      end
      pfirst_ff <= pfirst_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: sv/lfps_steer.sv
// ----------------------------------------------------------------------------
// lfps_steer
// Maps the PID output onto the two motor duty values and picks the drive
// mode: intersection, curve boost or clamped normal steering.
// ----------------------------------------------------------------------------
module lfps_steer import lfps_pkg::*; (
   input  logic signed [ACC_W-1:0] pid_out,
   input  logic [SPD_W-1:0]        base_speed,
   input  logic                    at_cross,
   input  logic [CNT_W-1:0]        active_cnt,
   output logic [SPD_W-1:0]        left_pwm,
   output logic [SPD_W-1:0]        right_pwm,
   output logic [MODE_W-1:0]       drive_mode
);

   localparam int NUM_W = ACC_W + 3;

   // divide by 256 (normal) or 512 (curve) toward zero, then clamp
   function automatic logic [SPD_W-1:0] to_speed(input logic signed [NUM_W-1:0] num,
                                                  input logic curve);
      logic signed [NUM_W-1:0] bias;
      logic signed [NUM_W-1:0] biased;
      logic signed [NUM_W-1:0] quo;
      logic signed [NUM_W-1:0] lo;
      logic signed [NUM_W-1:0] hi;
      bias   = '0;
      if (num < 0) begin
         bias = curve ? NUM_W'(511) : NUM_W'(255);
      end
      biased = num + bias;
      quo    = curve ? (biased >>> 9) : (biased >>> 8);
      lo     = curve ? '0 : NUM_W'(NORM_LO);
      hi     = curve ? NUM_W'(SPD_MAX) : NUM_W'(NORM_HI);
      if (quo < lo) begin
         quo = lo;
      end else if (quo > hi) begin
         quo = hi;
      end
      return quo[SPD_W-1:0];
   endfunction

   logic signed [NUM_W-1:0] q8;
   logic signed [NUM_W-1:0] q8x3;
   logic signed [NUM_W-1:0] base_n;
   logic signed [NUM_W-1:0] base_c;
   logic                    curve;

   always_comb begin
      q8     = NUM_W'(pid_out);
      q8x3   = (q8 <<< 1) + q8;
      base_n = $signed({{(NUM_W-SPD_W-8){1'b0}}, base_speed, 8'b0});
      base_c = $signed({{(NUM_W-SPD_W-9){1'b0}}, base_speed, 9'b0});
      curve  = active_cnt <= CURVE_MAX_CNT;
      if (at_cross) begin
         left_pwm   = CROSS_SPEED;
         right_pwm  = CROSS_SPEED;
         drive_mode = MODE_CROSS;
      end else if (curve) begin
         left_pwm   = to_speed(base_c + q8x3, 1'b1);
         right_pwm  = to_speed(base_c - q8x3, 1'b1);
         drive_mode = MODE_CURVE;
      end else begin
         left_pwm   = to_speed(base_n + q8, 1'b0);
         right_pwm  = to_speed(base_n - q8, 1'b0);
         drive_mode = MODE_NORMAL;
      end
   end

endmodule

// File: sv/line_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// PID steering for a line follower: sensor sample in, two motor duty values
// and a drive mode out, with a shared divider and multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/tready      tdata sensor_bits, tuser at_intersection
//  rsp_     out  rsp_tvalid/tready      tdata left/right pwm, tuser drive_mode
//  csr_     in   csr_we (no wait)       csr_addr, csr_wdata
//
//  An item passes from accept through the serial position divider (15 quotient
//  steps), the error step, 3 product terms in the shared multiplier, a drain
//  step and the output register when any sensor is active; when no sensor is
//  active the divider is skipped.
//  Synchronous active-high reset loads the gain defaults and clears the
//  integral and last error. The next item is accepted while a result waits;
//  a stalled result holds the sequencer before the output register.
// ----------------------------------------------------------------------------
module line_follow_pid_steering import lfps_pkg::*; #(
   parameter int NUM_SENSORS = LFPS_NUM_SENSORS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input transaction
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] sensor_bits
   input  logic [0:0]            req_tuser,   // [0] at_intersection
   // result transaction
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [7:0] left_pwm, [15:8] right_pwm
   output logic [1:0]            rsp_tuser,   // [1:0] drive_mode
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      TERM_P,
      TERM_I,
      TERM_D
   } term_type;

   state_type                  state_ff, state_in;
   term_type                   term_ff, term_in;
   logic signed [GAIN_W-1:0]   prop_ff, prop_in;
   logic signed [GAIN_W-1:0]   integ_ff, integ_in;
   logic signed [GAIN_W-1:0]   dgain_ff, dgain_in;
   logic [SPD_W-1:0]           base_ff, base_in;
   logic signed [ERR_W-1:0]    prev_err_ff, prev_err_in;
   logic signed [SUM_W-1:0]    err_sum_ff, err_sum_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [DLT_W-1:0]    dlt_ff, dlt_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       cross_ff, cross_in;
   logic                       empty_hi_ff, empty_hi_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SPD_W-1:0]           left_ff, left_in;
   logic [SPD_W-1:0]           right_ff, right_in;
   logic [MODE_W-1:0]          mode_ff, mode_in;

   logic                       accept;
   logic [IDX_W-1:0]           idx_sum;
   logic [CNT_W-1:0]           act_cnt;
   logic [WSUM_W-1:0]          wsum;
   logic                       div_start;
   logic                       div_busy;
   logic [WSUM_W-1:0]          div_quo;
   logic [POS_W-1:0]           pos;
   logic signed [DLT_W-1:0]    pos_off;
   logic signed [ERR_W-1:0]    err_new;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_new;
   mac_ctrl_type               mac_ctrl;
   logic signed [GAIN_W-1:0]   mac_gain;
   logic signed [OPND_W-1:0]   mac_opnd;
   logic signed [ACC_W-1:0]    pid_out;
   logic [SPD_W-1:0]           left_c;
   logic [SPD_W-1:0]           right_c;
   logic [MODE_W-1:0]          mode_c;

   assign accept = req_tvalid && req_tready;

   // active sensor count and index sum of the sample
   always_comb begin
      idx_sum = '0;
      act_cnt = '0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (i < NUM_SENSORS && req_tdata[i]) begin
            idx_sum = idx_sum + IDX_W'(i);
            act_cnt = act_cnt + 1'b1;
         end
      end
      wsum      = WSUM_W'(idx_sum) * WSUM_W'(POS_STEP);
      div_start = accept && (act_cnt != '0);
   end

   lfps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wsum),
      .divisor  (act_cnt),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // position, saturated error and integral
   always_comb begin
      if (cnt_ff == '0) begin
         pos = empty_hi_ff ? POS_W'(POS_RIGHT) : '0;
      end else begin
         pos = div_quo[POS_W-1:0];
      end
      pos_off = $signed({1'b0, pos}) - DLT_W'(POS_CENTER);
      if (pos_off > DLT_W'(ERR_MAX)) begin
         err_new = ERR_W'(ERR_MAX);
      end else if (pos_off < DLT_W'(ERR_MIN)) begin
         err_new = ERR_W'(ERR_MIN);
      end else begin
         err_new = pos_off[ERR_W-1:0];
      end
      sum_wide = (SUM_W+1)'(err_sum_ff) + (SUM_W+1)'(err_new);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_new = sum_wide[SUM_W-1:0];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mac_ctrl.valid = (state_ff == ST_MAC);
      mac_ctrl.first = (term_ff == TERM_P);
      case (term_ff)
         TERM_P: begin
            mac_gain = prop_ff;
            mac_opnd = OPND_W'(err_ff);
         end
         TERM_I: begin
            mac_gain = integ_ff;
            mac_opnd = OPND_W'(err_sum_ff);
         end
         default: begin
            mac_gain = dgain_ff;
            mac_opnd = OPND_W'(dlt_ff);
         end
      endcase
   end

   lfps_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .gain  (mac_gain),
      .opnd  (mac_opnd),
      .acc   (pid_out)
   );

   lfps_steer u_steer (
      .pid_out    (pid_out),
      .base_speed (base_ff),
      .at_cross   (cross_ff),
      .active_cnt (cnt_ff),
      .left_pwm   (left_c),
      .right_pwm  (right_c),
      .drive_mode (mode_c)
   );

   // sequencer and register next values
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      prop_in      = prop_ff;
      integ_in     = integ_ff;
      dgain_in     = dgain_ff;
      base_in      = base_ff;
      prev_err_in  = prev_err_ff;
      err_sum_in   = err_sum_ff;
      err_in       = err_ff;
      dlt_in       = dlt_ff;
      cnt_in       = cnt_ff;
      cross_in     = cross_ff;
      empty_hi_in  = empty_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      left_in      = left_ff;
      right_in     = right_ff;
      mode_in      = mode_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PROP_GAIN:  prop_in  = csr_wdata;
            CSR_INTEG_GAIN: integ_in = csr_wdata;
            CSR_DERIV_GAIN: dgain_in = csr_wdata;
            CSR_BASE_SPEED: base_in  = csr_wdata[SPD_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in      = act_cnt;
               cross_in    = req_tuser[0];
               empty_hi_in = !prev_err_ff[ERR_W-1] && (prev_err_ff != '0);
               state_in    = (act_cnt == '0) ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in      = err_new;
            err_sum_in  = sum_new;
            dlt_in      = DLT_W'(err_new) - DLT_W'(prev_err_ff);
            prev_err_in = err_new;
            term_in     = TERM_P;
            state_in    = ST_MAC;
         end
         ST_MAC: begin
            unique case (term_ff)
               TERM_P:  term_in = TERM_I;
               TERM_I:  term_in = TERM_D;
               default: state_in = ST_DRAIN;
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               left_in      = left_c;
               right_in     = right_c;
               mode_in      = mode_c;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_P;
         prop_ff      <= PROP_GAIN_RST;
         integ_ff     <= INTEG_GAIN_RST;
         dgain_ff     <= DERIV_GAIN_RST;
         base_ff      <= BASE_SPEED_RST;
         prev_err_ff  <= '0;
         err_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         prop_ff      <= prop_in;
         integ_ff     <= integ_in;
         dgain_ff     <= dgain_in;
         base_ff      <= base_in;
         prev_err_ff  <= prev_err_in;
         err_sum_ff   <= err_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff      <= err_in;
      dlt_ff      <= dlt_in;
      cnt_ff      <= cnt_in;
      cross_ff    <= cross_in;
      empty_hi_ff <= empty_hi_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      mode_ff     <= mode_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = mode_ff;

endmodule

// File: tb/line_follow_pid_steering_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_checker
// Watches the sample, result and register ports of the steering block,
// predicts the motor duty values and drive mode of each accepted sample,
// and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_checker import lfps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] sensor_bits
   input  logic [0:0]            req_tuser,   // [0] at_intersection
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,   // [7:0] left_pwm, [15:8] right_pwm
   input  logic [1:0]            rsp_tuser,   // [1:0] drive_mode
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    steer_pending,
   output int                    mismatch_count
);

   typedef struct packed {
      logic [SPD_W-1:0] left_pwm;
      logic [SPD_W-1:0] right_pwm;
      mode_type         drive_mode;
   } steer_type;

   // shadow copy of the registers
   logic signed [GAIN_W-1:0] prop_gain;
   logic signed [GAIN_W-1:0] integ_gain;
   logic signed [GAIN_W-1:0] deriv_gain;
   logic [SPD_W-1:0]         base_speed;

   // controller state
   longint last_error;
   longint error_total;

   steer_type pending_steer_q[$];

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // one controller step: position, error, pid sum and motor speeds
   function automatic steer_type predict_steering(logic [SENSOR_W-1:0] bits, logic crossing);
      steer_type r;
      int     i;
      int     active;
      longint idx_sum;
      longint position;
      longint err;
      longint q8;
      longint base;
      longint left;
      longint right;
      active  = 0;
      idx_sum = 0;
      for (i = 0; i < LFPS_NUM_SENSORS && i < SENSOR_W; i++) begin
         if (bits[i]) begin
            idx_sum += longint'(i) * POS_STEP;
            active++;
         end
      end
      // lost line: hold the side the line was last seen on
      if (active == 0)
         position = (last_error > 0) ? POS_RIGHT : 0;
      else
         position = idx_sum / active;
      err = clamp_range(position - POS_CENTER, ERR_MIN, ERR_MAX);
      error_total = clamp_range(error_total + err, -64'sd2147483648, 64'sd2147483647);
      q8 = longint'(prop_gain) * err + longint'(integ_gain) * error_total
         + longint'(deriv_gain) * (err - last_error);
      base = longint'(base_speed);
      if (crossing) begin
         left  = CROSS_SPEED;
         right = CROSS_SPEED;
         r.drive_mode = MODE_CROSS;
      end else if (active <= CURVE_MAX_CNT) begin
         // 1.5x boost in Q.9
         left  = (base * 512 + 3 * q8) / 512;
         right = (base * 512 - 3 * q8) / 512;
         r.drive_mode = MODE_CURVE;
      end else begin
         left  = clamp_range((base * 256 + q8) / 256, NORM_LO, NORM_HI);
         right = clamp_range((base * 256 - q8) / 256, NORM_LO, NORM_HI);
         r.drive_mode = MODE_NORMAL;
      end
      left  = clamp_range(left, 0, SPD_MAX);
      right = clamp_range(right, 0, SPD_MAX);
      r.left_pwm  = left[SPD_W-1:0];
      r.right_pwm = right[SPD_W-1:0];
      last_error  = err;
      return r;
   endfunction

   // track registers, predict on accepted samples, compare accepted results
   always @(posedge clock) begin : monitor
      steer_type want;
      if (reset) begin
         prop_gain   = PROP_GAIN_RST;
         integ_gain  = INTEG_GAIN_RST;
         deriv_gain  = DERIV_GAIN_RST;
         base_speed  = BASE_SPEED_RST;
         last_error  = 0;
         error_total = 0;
         pending_steer_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_PROP_GAIN:  prop_gain  = csr_wdata;
               CSR_INTEG_GAIN: integ_gain = csr_wdata;
               CSR_DERIV_GAIN: deriv_gain = csr_wdata;
               CSR_BASE_SPEED: base_speed = csr_wdata[SPD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_steer_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result left %0d right %0d mode %0d", $realtime,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tuser);
               mismatch_count++;
            end else begin
               want = pending_steer_q.pop_front();
               if (rsp_tdata[7:0] !== want.left_pwm || rsp_tdata[15:8] !== want.right_pwm ||
                   rsp_tuser !== want.drive_mode) begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch expected left %0d right %0d mode %0d, got %0d %0d %0d",
                              $realtime, want.left_pwm, want.right_pwm, want.drive_mode,
                              rsp_tdata[7:0], rsp_tdata[15:8], rsp_tuser);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_steer_q.push_back(predict_steering(req_tdata, req_tuser[0]));
      end
      steer_pending = pending_steer_q.size();
   end

endmodule

// File: tb/line_follow_pid_steering_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_tb
// Drives sensor samples through the steering block under several gain and
// speed settings with random gaps and result stalls; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_tb import lfps_pkg::*; ();

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] sensor_bits
   logic [0:0]            req_tuser;   // [0] at_intersection
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;   // [7:0] left_pwm, [15:8] right_pwm
   logic [1:0]            rsp_tuser;   // [1:0] drive_mode
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int steer_pending;
   int mismatch_count;
   int req_max_gap;
   int rsp_max_stall;

   line_follow_pid_steering u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   line_follow_pid_steering_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .steer_pending  (steer_pending),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // one sample transaction; entered and left at a falling edge
   task automatic send_sample(input logic [7:0] bits, input logic crossing);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= bits;
      req_tuser  <= crossing;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [15:0] prop, input logic [15:0] integ,
                                input logic [15:0] deriv, input logic [7:0] base);
      write_reg(CSR_PROP_GAIN, prop);
      write_reg(CSR_INTEG_GAIN, integ);
      write_reg(CSR_DERIV_GAIN, deriv);
      write_reg(CSR_BASE_SPEED, {8'h00, base});
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // hold the sender until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (steer_pending != 0) @(negedge clock);
   endtask

   // result side: stall a random number of cycles after each transaction
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            stall = $urandom_range(0, rsp_max_stall);
            if (stall > 0) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [7:0] bits;
      logic       crossing;
      int         phase;
      int         n;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      req_max_gap   = 4;
      rsp_max_stall = 4;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed samples at reset settings
      send_sample(8'h18, 1'b0);   // centered
      send_sample(8'h80, 1'b0);   // far right sensor alone
      send_sample(8'h00, 1'b0);   // line lost after a positive error
      send_sample(8'h00, 1'b0);   // still lost, error held high
      send_sample(8'h01, 1'b0);   // far left sensor alone
      send_sample(8'h00, 1'b0);   // line lost after a negative error
      send_sample(8'hFF, 1'b0);   // all sensors
      send_sample(8'h0F, 1'b0);
      send_sample(8'hF0, 1'b0);
      send_sample(8'h07, 1'b0);
      send_sample(8'hE0, 1'b0);
      send_sample(8'h03, 1'b0);   // two sensors: curve boost
      send_sample(8'hC0, 1'b0);
      send_sample(8'h81, 1'b0);   // two sensors far apart
      send_sample(8'hAA, 1'b0);
      send_sample(8'h55, 1'b0);
      send_sample(8'h3C, 1'b0);
      send_sample(8'h18, 1'b1);   // intersection
      send_sample(8'h00, 1'b1);   // intersection with no sensor
      send_sample(8'hFF, 1'b1);
      send_sample(8'h7E, 1'b0);
      send_sample(8'h02, 1'b0);

      // random samples under several settings
      for (phase = 1; phase <= 8; phase++) begin
         drain_results();
         case (phase)
            1: load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF);
            2: load_settings(16'h8000, 16'h8000, 16'h8000, 8'h00);
            3: load_settings(16'd256, 16'd0, 16'd0, 8'd128);
            4: load_settings(PROP_GAIN_RST, 16'd2, DERIV_GAIN_RST, BASE_SPEED_RST);
            default: begin
               if (phase % 2 == 1)
                  load_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
               else
                  load_settings(16'($urandom_range(0, 1023) - 512),
                                16'($urandom_range(0, 15) - 8),
                                16'($urandom_range(0, 1023) - 512),
                                8'($urandom_range(0, 255)));
            end
         endcase
         req_max_gap   = (phase % 3 == 0) ? 0 : 16;
         rsp_max_stall = (phase % 4 == 1) ? 0 : 16;
         for (n = 0; n < 75; n++) begin
            // mostly line-shaped patterns, some lost line and noise
            case ($urandom_range(0, 9))
               0:       bits = 8'h00;
               1, 2:    bits = 8'h01 << $urandom_range(0, 7);
               3:       bits = 8'h03 << $urandom_range(0, 6);
               4:       bits = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
               5, 6:    bits = 8'h07 << $urandom_range(0, 5);
               7:       bits = 8'h0F << $urandom_range(0, 4);
               default: bits = 8'($urandom_range(0, 255));
            endcase
            crossing = ($urandom_range(0, 7) == 0);
            send_sample(bits, crossing);
         end
      end

      drain_results();
      repeat (30) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
